// ----- hdl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

	// Input word: hue in degrees, saturation and value in percent
	typedef struct packed {
		logic signed [10:0] hue_deg;
		logic signed [7:0]  sat_pct;
		logic signed [7:0]  val_pct;
	} hsv_word_t;

	// Output word: 8-bit color channels
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_word_t;

	// 60-degree hue sectors; SEC_WRAP is a hue of exactly 360
	typedef enum logic [2:0] {
		SEC_RY   = 3'd0,
		SEC_YG   = 3'd1,
		SEC_GC   = 3'd2,
		SEC_CB   = 3'd3,
		SEC_BM   = 3'd4,
		SEC_MR   = 3'd5,
		SEC_WRAP = 3'd6
	} sector_t;

	localparam logic [9:0]  HUE_TOP     = 10'd360;
	localparam logic [8:0]  HUE_WRAP    = 9'd359;
	localparam logic [6:0]  PCT_TOP     = 7'd100;
	localparam logic [5:0]  SECTOR_DEG  = 6'd60;
	// counts are in units of 1/600000; v*6000 is the full value count
	localparam logic [12:0] FULL_SCALE  = 13'd6000;
	// byte = floor((17*n + 20000) / 40000), 40000 = 64 * 625
	localparam logic [4:0]  ROUND_MUL   = 5'd17;
	localparam logic [14:0] ROUND_BIAS  = 15'd20000;
	localparam int          DIV_SHIFT   = 6;
	localparam logic [9:0]  DIV_REM     = 10'd625;
	// floor(2^24 / 625): estimate is exact or one low for 18-bit dividends
	localparam logic [14:0] DIV_RECIP   = 15'd26843;
	localparam int          RECIP_SHIFT = 24;

	// Per-item data leaving the front stages
	typedef struct packed {
		logic [6:0]  val;
		logic [13:0] prod;
		logic [5:0]  peak_gap;
		sector_t     sector;
	} prep_t;

	// Scaled channel dividends, already divided by 64
	typedef struct packed {
		logic [17:0] red;
		logic [17:0] green;
		logic [17:0] blue;
	} div_set_t;

endpackage

// ----- hdl/hsv2rgb_prep.sv -----
module hsv2rgb_prep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  hsv2rgb_pkg::hsv_word_t in_word,
	output logic                   out_valid,
	output hsv2rgb_pkg::prep_t     out_data
);

	logic       vld_s1;
	logic [8:0] hue_s1;
	logic [6:0] sat_s1;
	logic [6:0] val_s1;

	logic       vld_s2;
	hsv2rgb_pkg::prep_t data_s2;

	logic [8:0] hue_c;
	logic [6:0] sat_c;
	logic [6:0] val_c;

	hsv2rgb_pkg::sector_t sector_c;
	logic [8:0] base_c;
	logic [8:0] rem_c;
	logic [5:0] dist_c;

	// stage 1: clamp
	always_comb begin
		if (in_word.hue_deg[10]) begin
			hue_c = '0;
		end else if (in_word.hue_deg[9:0] > hsv2rgb_pkg::HUE_TOP) begin
			hue_c = hsv2rgb_pkg::HUE_WRAP;
		end else begin
			hue_c = in_word.hue_deg[8:0];
		end

		if (in_word.sat_pct[7]) begin
			sat_c = '0;
		end else if (in_word.sat_pct[6:0] > hsv2rgb_pkg::PCT_TOP) begin
			sat_c = hsv2rgb_pkg::PCT_TOP;
		end else begin
			sat_c = in_word.sat_pct[6:0];
		end

		if (in_word.val_pct[7]) begin
			val_c = '0;
		end else if (in_word.val_pct[6:0] > hsv2rgb_pkg::PCT_TOP) begin
			val_c = hsv2rgb_pkg::PCT_TOP;
		end else begin
			val_c = in_word.val_pct[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1 <= hue_c;
			sat_s1 <= sat_c;
			val_s1 <= val_c;
		end
	end

	// stage 2: sector, distance from sector peak, v*s
	always_comb begin
		if (hue_s1 < 9'd60) begin
			sector_c = hsv2rgb_pkg::SEC_RY;
		end else if (hue_s1 < 9'd120) begin
			sector_c = hsv2rgb_pkg::SEC_YG;
		end else if (hue_s1 < 9'd180) begin
			sector_c = hsv2rgb_pkg::SEC_GC;
		end else if (hue_s1 < 9'd240) begin
			sector_c = hsv2rgb_pkg::SEC_CB;
		end else if (hue_s1 < 9'd300) begin
			sector_c = hsv2rgb_pkg::SEC_BM;
		end else if (hue_s1 < 9'd360) begin
			sector_c = hsv2rgb_pkg::SEC_MR;
		end else begin
			sector_c = hsv2rgb_pkg::SEC_WRAP;
		end

		unique case (sector_c)
			hsv2rgb_pkg::SEC_RY:   base_c = 9'd0;
			hsv2rgb_pkg::SEC_YG:   base_c = 9'd60;
			hsv2rgb_pkg::SEC_GC:   base_c = 9'd120;
			hsv2rgb_pkg::SEC_CB:   base_c = 9'd180;
			hsv2rgb_pkg::SEC_BM:   base_c = 9'd240;
			hsv2rgb_pkg::SEC_MR:   base_c = 9'd300;
			default:               base_c = 9'd360;
		endcase

		rem_c = hue_s1 - base_c;
		// odd sectors rise from the peak, even sectors fall toward it
		if (sector_c[0]) begin
			dist_c = rem_c[5:0];
		end else begin
			dist_c = hsv2rgb_pkg::SECTOR_DEG - rem_c[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2.val      <= val_s1;
			data_s2.prod     <= 14'(val_s1) * 14'(sat_s1);
			data_s2.peak_gap <= dist_c;
			data_s2.sector   <= sector_c;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = data_s2;

endmodule

// ----- hdl/hsv2rgb_mix.sv -----
module hsv2rgb_mix (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  hsv2rgb_pkg::prep_t     in_data,
	output logic                   out_valid,
	output hsv2rgb_pkg::div_set_t  out_data
);

	logic        vld_s3;
	logic [19:0] full_s3;
	logic [19:0] p60_s3;
	logic [19:0] px_s3;
	hsv2rgb_pkg::sector_t sector_s3;

	logic        vld_s4;
	hsv2rgb_pkg::div_set_t div_s4;

	logic [19:0] n_c;
	logic [19:0] n_x;
	logic [19:0] n_z;
	logic [19:0] n_red;
	logic [19:0] n_green;
	logic [19:0] n_blue;
	logic [23:0] y_red;
	logic [23:0] y_green;
	logic [23:0] y_blue;

	// stage 3: counts for full value, chroma and chroma*dist
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s3   <= 20'(in_data.val) * 20'(hsv2rgb_pkg::FULL_SCALE);
			p60_s3    <= 20'(in_data.prod) * 20'(hsv2rgb_pkg::SECTOR_DEG);
			px_s3     <= 20'(in_data.prod) * 20'(in_data.peak_gap);
			sector_s3 <= in_data.sector;
		end
	end

	// stage 4: per-channel count, then 17*n + bias, divided by 64
	always_comb begin
		n_c = full_s3;
		n_x = full_s3 - px_s3;
		n_z = full_s3 - p60_s3;

		unique case (sector_s3)
			hsv2rgb_pkg::SEC_RY: begin
				n_red = n_c; n_green = n_x; n_blue = n_z;
			end
			hsv2rgb_pkg::SEC_YG: begin
				n_red = n_x; n_green = n_c; n_blue = n_z;
			end
			hsv2rgb_pkg::SEC_GC: begin
				n_red = n_z; n_green = n_c; n_blue = n_x;
			end
			hsv2rgb_pkg::SEC_CB: begin
				n_red = n_z; n_green = n_x; n_blue = n_c;
			end
			hsv2rgb_pkg::SEC_BM: begin
				n_red = n_x; n_green = n_z; n_blue = n_c;
			end
			default: begin
				n_red = n_c; n_green = n_z; n_blue = n_x;
			end
		endcase

		y_red   = 24'(n_red) * 24'(hsv2rgb_pkg::ROUND_MUL) + 24'(hsv2rgb_pkg::ROUND_BIAS);
		y_green = 24'(n_green) * 24'(hsv2rgb_pkg::ROUND_MUL)
			+ 24'(hsv2rgb_pkg::ROUND_BIAS);
		y_blue  = 24'(n_blue) * 24'(hsv2rgb_pkg::ROUND_MUL) + 24'(hsv2rgb_pkg::ROUND_BIAS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s4.red   <= y_red[23:hsv2rgb_pkg::DIV_SHIFT];
			div_s4.green <= y_green[23:hsv2rgb_pkg::DIV_SHIFT];
			div_s4.blue  <= y_blue[23:hsv2rgb_pkg::DIV_SHIFT];
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = div_s4;

endmodule

// ----- hdl/hsv2rgb_quant.sv -----
module hsv2rgb_quant (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  hsv2rgb_pkg::div_set_t  in_data,
	output logic                   out_valid,
	output hsv2rgb_pkg::rgb_word_t out_word
);

	localparam int NCH = 3;

	logic [17:0] z_in [NCH];

	logic        vld_s5;
	logic [17:0] z_s5  [NCH];
	logic [8:0]  q0_s5 [NCH];

	logic        vld_s6;
	logic [7:0]  byte_s6 [NCH];

	logic [32:0] prod_c [NCH];
	logic [18:0] rem_c  [NCH];
	logic [8:0]  q_c    [NCH];
	logic [7:0]  byte_c [NCH];

	assign z_in[0] = in_data.red;
	assign z_in[1] = in_data.green;
	assign z_in[2] = in_data.blue;

	// stage 5: quotient estimate by reciprocal multiply
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			prod_c[i] = 33'(z_in[i]) * 33'(hsv2rgb_pkg::DIV_RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCH; i++) begin
				z_s5[i]  <= z_in[i];
				q0_s5[i] <= prod_c[i][32:hsv2rgb_pkg::RECIP_SHIFT];
			end
		end
	end

	// stage 6: estimate may be one low; fix it from the remainder
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			rem_c[i] = 19'(z_s5[i]) - 19'(q0_s5[i]) * 19'(hsv2rgb_pkg::DIV_REM);
			q_c[i]   = q0_s5[i] + 9'(rem_c[i] >= 19'(hsv2rgb_pkg::DIV_REM));
			byte_c[i] = q_c[i][8] ? 8'hff : q_c[i][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCH; i++) begin
				byte_s6[i] <= byte_c[i];
			end
		end
	end

	assign out_valid          = vld_s6;
	assign out_word.red_out   = byte_s6[0];
	assign out_word.green_out = byte_s6[1];
	assign out_word.blue_out  = byte_s6[2];

endmodule

// ----- hdl/hsv_to_rgb_converter.sv -----
// HSV to RGB color converter.
// Input channel: hsv_valid / hsv_stall / hsv_word carries one color word:
// hue in degrees, saturation and value in percent, all two's complement.
// Out-of-range inputs are clamped (negative to 0, hue above 360 to 359,
// saturation and value above 100 to 100).
// Output channel: rgb_valid / rgb_stall / rgb_word carries 8-bit red,
// green and blue, each rounded half up from the exact value.
// The pipeline has 6 register stages; rgb_valid rises once the accepted
// input word has passed through all of them.
// One word is accepted every cycle while the output is not stalled. The
// stages are, in order: clamp, sector, products, channel select,
// reciprocal divide, correction.
// When rgb_stall is high with a word waiting, every stage holds and
// hsv_stall rises in the same cycle; bubbles are not squeezed out meanwhile.
// Reset clears all stage valid bits; no word is presented after reset
// until one is accepted.
module hsv_to_rgb_converter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   hsv_valid,
	output logic                   hsv_stall,
	input  hsv2rgb_pkg::hsv_word_t hsv_word,
	output logic                   rgb_valid,
	input  logic                   rgb_stall,
	output hsv2rgb_pkg::rgb_word_t rgb_word
);

	logic                  en;
	logic                  prep_valid;
	hsv2rgb_pkg::prep_t    prep_data;
	logic                  mix_valid;
	hsv2rgb_pkg::div_set_t mix_data;

	assign en        = !rgb_valid || !rgb_stall;
	assign hsv_stall = !en;

	hsv2rgb_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (hsv_valid),
		.in_word   (hsv_word),
		.out_valid (prep_valid),
		.out_data  (prep_data)
	);

	hsv2rgb_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_valid),
		.in_data   (prep_data),
		.out_valid (mix_valid),
		.out_data  (mix_data)
	);

	hsv2rgb_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mix_valid),
		.in_data   (mix_data),
		.out_valid (rgb_valid),
		.out_word  (rgb_word)
	);

endmodule
